### rtl/ttcb_pkg.sv
// ----------------------------------------------------------------------------
// ttcb_pkg
// Shared types and codes for the text terminal cell buffer: request and
// result beats, controller states, and controller/datapath command bundles.
// ----------------------------------------------------------------------------
package ttcb_pkg;

    localparam logic [7:0] CODE_NEWLINE = 8'd10;
    localparam logic [7:0] CODE_TAB     = 8'd9;
    localparam logic [3:0] TAB_RESET    = 4'd3;

    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_READ  = 1'b1;

    // register index on the APB port (byte address 4*index)
    localparam logic REG_TAB_WIDTH = 1'b0;

    typedef struct packed {
        logic       req_type;
        logic [7:0] char_code;
        logic [5:0] read_col;
        logic [4:0] read_row;
    } ttcb_req_t;

    typedef struct packed {
        logic [7:0] cell_code;
        logic [5:0] cursor_col;
        logic [4:0] cursor_row;
        logic       scrolled;
    } ttcb_rsp_t;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_DECODE,
        ST_RD_WAIT,
        ST_COPY,
        ST_CLEAR_ROW,
        ST_STORE,
        ST_DONE
    } ttcb_state_t;

    typedef struct packed {
        logic take;         // controller can take a request beat
        logic rd_issue;     // read one cell for a read request
        logic load_cell;    // capture read data into the result
        logic cur_newline;  // cursor to column 0 of next row (or stay on last)
        logic tab_step;     // apply tab to cursor
        logic store;        // store char at cursor, advance column
        logic sweep_start;  // restart sweep counter at cell 0
        logic copy_step;    // move one cell up by one row
        logic clr_step;     // clear one cell
        logic set_scrolled; // flag result as scrolled
        logic out_load;     // load result register
    } ttcb_cmd_t;

    typedef struct packed {
        logic is_read;
        logic is_newline;
        logic is_tab;
        logic col_past;     // cursor column beyond the last column
        logic last_row;
        logic copy_last;
        logic sweep_last;
        logic out_free;
    } ttcb_sts_t;

endpackage

### rtl/ttcb_ctrl.sv
// ----------------------------------------------------------------------------
// ttcb_ctrl
// Sequencer for the cell buffer: reset clearing pass, request decode, row
// scroll sweep, cell store and result hand-off.
// ----------------------------------------------------------------------------
module ttcb_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    input  ttcb_pkg::ttcb_sts_t sts,
    output ttcb_pkg::ttcb_cmd_t cmd
);
    import ttcb_pkg::*;

    ttcb_state_t state_reg;
    ttcb_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_INIT;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_INIT: begin
                if (sts.sweep_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE: begin
                if (sts.is_read) begin
                    state_next = ST_RD_WAIT;
                end else if (sts.is_newline) begin
                    state_next = sts.last_row ? ST_COPY : ST_DONE;
                end else if (sts.is_tab) begin
                    state_next = ST_DONE;
                end else if (sts.col_past && sts.last_row) begin
                    state_next = ST_COPY;
                end else begin
                    state_next = ST_STORE;
                end
            end
            ST_RD_WAIT: state_next = ST_DONE;
            ST_COPY: begin
                if (sts.copy_last) begin
                    state_next = ST_CLEAR_ROW;
                end
            end
            ST_CLEAR_ROW: begin
                if (sts.sweep_last) begin
                    state_next = sts.is_newline ? ST_DONE : ST_STORE;
                end
            end
            ST_STORE: state_next = ST_DONE;
            ST_DONE: begin
                if (sts.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_INIT;
        endcase
    end

    always_comb begin
        cmd = '0;
        case (state_reg)
            ST_INIT: cmd.clr_step = 1'b1;
            ST_IDLE: cmd.take = 1'b1;
            ST_DECODE: begin
                if (sts.is_read) begin
                    cmd.rd_issue = 1'b1;
                end else if (sts.is_newline) begin
                    if (sts.last_row) begin
                        cmd.sweep_start = 1'b1;
                    end else begin
                        cmd.cur_newline = 1'b1;
                    end
                end else if (sts.is_tab) begin
                    cmd.tab_step = 1'b1;
                end else if (sts.col_past) begin
                    if (sts.last_row) begin
                        cmd.sweep_start = 1'b1;
                    end else begin
                        cmd.cur_newline = 1'b1;
                    end
                end
            end
            ST_RD_WAIT: cmd.load_cell = 1'b1;
            ST_COPY: cmd.copy_step = 1'b1;
            ST_CLEAR_ROW: begin
                cmd.clr_step = 1'b1;
                if (sts.sweep_last) begin
                    cmd.cur_newline  = 1'b1;
                    cmd.set_scrolled = 1'b1;
                end
            end
            ST_STORE: cmd.store = 1'b1;
            ST_DONE: cmd.out_load = sts.out_free;
            default: cmd = '0;
        endcase
    end

endmodule

### rtl/ttcb_datapath.sv
// ----------------------------------------------------------------------------
// ttcb_datapath
// Cell memory, cursor, sweep counter, write stage and result register.
// ----------------------------------------------------------------------------
module ttcb_datapath #(
    parameter int COLS = 40,
    parameter int ROWS = 25
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic [3:0]          tab_width,
    input  logic                s_valid,
    input  ttcb_pkg::ttcb_req_t s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output ttcb_pkg::ttcb_rsp_t m_data,
    input  ttcb_pkg::ttcb_cmd_t cmd,
    output ttcb_pkg::ttcb_sts_t sts
);
    import ttcb_pkg::*;

    localparam int TOTAL  = COLS * ROWS;
    localparam int COPY_N = COLS * (ROWS - 1);
    localparam int AW     = $clog2(TOTAL);
    localparam int CW     = $clog2(COLS + 1);
    localparam int RW     = $clog2(ROWS);
    localparam int TW     = CW + 1;

    logic [7:0] mem [TOTAL];

    ttcb_req_t     req_reg;
    logic [CW-1:0] col_reg, col_next;
    logic [RW-1:0] line_reg, line_next;
    logic [AW-1:0] cnt_reg, cnt_next;
    logic          wr_en_reg;
    logic [AW-1:0] wr_addr_reg;
    logic [7:0]    wr_fixed_reg;
    logic          wr_copy_reg;
    logic [7:0]    rdata_reg;
    logic [7:0]    cell_reg;
    logic          scrolled_reg;
    logic          m_valid_reg;
    ttcb_rsp_t     m_data_reg;

    logic          accept;
    logic          in_range;
    logic [AW-1:0] rd_cell_addr;
    logic [AW-1:0] cur_addr;
    logic [AW-1:0] rd_addr;
    logic          rd_en;
    logic [TW-1:0] tab_sum;
    ttcb_rsp_t     rsp;

    assign accept   = cmd.take && s_valid;
    assign in_range = ({2'b0, req_reg.read_col} < 8'(COLS))
                   && ({2'b0, req_reg.read_row} < 7'(ROWS));
    assign rd_cell_addr = AW'(req_reg.read_row) * AW'(COLS) + AW'(req_reg.read_col);
    assign cur_addr     = AW'(line_reg) * AW'(COLS) + AW'(col_reg);
    assign rd_en   = cmd.copy_step || (cmd.rd_issue && in_range);
    assign rd_addr = cmd.copy_step ? (cnt_reg + AW'(COLS)) : rd_cell_addr;
    assign tab_sum = TW'(col_reg) + TW'(tab_width);

    // status
    always_comb begin
        sts            = '0;
        sts.is_read    = (req_reg.req_type == REQ_READ);
        sts.is_newline = (req_reg.char_code == CODE_NEWLINE);
        sts.is_tab     = (req_reg.char_code == CODE_TAB);
        sts.col_past   = (col_reg >= CW'(COLS));
        sts.last_row   = (line_reg >= RW'(ROWS - 1));
        sts.copy_last  = (cnt_reg == AW'(COPY_N - 1));
        sts.sweep_last = (cnt_reg == AW'(TOTAL - 1));
        sts.out_free   = !m_valid_reg || m_ready;
    end

    // cursor and sweep counter
    always_comb begin
        col_next  = col_reg;
        line_next = line_reg;
        if (cmd.cur_newline) begin
            col_next = '0;
            if (line_reg < RW'(ROWS - 1)) begin
                line_next = line_reg + 1'b1;
            end
        end else if (cmd.tab_step) begin
            if (tab_sum < TW'(COLS)) begin
                col_next = CW'(tab_sum);
            end
        end else if (cmd.store) begin
            col_next = col_reg + 1'b1;
        end
    end

    always_comb begin
        cnt_next = cnt_reg;
        if (cmd.sweep_start) begin
            cnt_next = '0;
        end else if (cmd.copy_step || cmd.clr_step) begin
            cnt_next = cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg      <= '0;
            line_reg     <= '0;
            cnt_reg      <= '0;
            wr_en_reg    <= 1'b0;
            m_valid_reg  <= 1'b0;
            scrolled_reg <= 1'b0;
        end else begin
            col_reg   <= col_next;
            line_reg  <= line_next;
            cnt_reg   <= cnt_next;
            wr_en_reg <= cmd.copy_step || cmd.clr_step || cmd.store;
            if (accept) begin
                scrolled_reg <= 1'b0;
            end else if (cmd.set_scrolled) begin
                scrolled_reg <= 1'b1;
            end
            if (cmd.out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (accept) begin
            req_reg  <= s_data;
            cell_reg <= '0;
        end else if (cmd.load_cell) begin
            cell_reg <= in_range ? rdata_reg : 8'd0;
        end
        // write stage: the cell write is registered and lands in the cycle after it is issued
        wr_addr_reg  <= cmd.store ? cur_addr : cnt_reg;
        wr_fixed_reg <= cmd.store ? req_reg.char_code : 8'd0;
        wr_copy_reg  <= cmd.copy_step;
        if (cmd.out_load) begin
            m_data_reg <= rsp;
        end
    end

    always_comb begin
        rsp            = '0;
        rsp.cell_code  = cell_reg;
        rsp.cursor_col = 6'(col_reg);
        rsp.cursor_row = 5'(line_reg);
        rsp.scrolled   = scrolled_reg;
    end

    // cell memory: one read port, one write port
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rdata_reg <= mem[rd_addr];
        end
        if (wr_en_reg) begin
            mem[wr_addr_reg] <= wr_copy_reg ? rdata_reg : wr_fixed_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

### rtl/text_terminal_cell_buffer_unit.sv
// Sequence: read and store pass DECODE, RD_WAIT or STORE, then DONE; tab and plain newline
//   go from DECODE to DONE; a scroll adds a sweep (one cell moved or cleared per cycle).
// Throughput: one item at a time; the next item can be taken in the cycle after the result loads,
//   and the one-cell-per-cycle sweep through the cell memory sets the scroll length.
// Reset: cursor to 0,0 and tab_width 3; a clearing pass over all COLS*ROWS cells zeroes
//   the cell memory while s_ready stays low (APB writes still taken).
// ----------------------------------------------------------------------------
// text_terminal_cell_buffer_unit
// Character-cell terminal store with cursor, newline scroll, tab and reads.
// ----------------------------------------------------------------------------
module text_terminal_cell_buffer_unit #(
    parameter int COLS = 40,
    parameter int ROWS = 25
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    input  logic                s_valid,
    output logic                s_ready,
    input  ttcb_pkg::ttcb_req_t s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output ttcb_pkg::ttcb_rsp_t m_data
);
    import ttcb_pkg::*;

    logic [3:0] tab_width_reg;
    ttcb_cmd_t  cmd;
    ttcb_sts_t  sts;
    logic       reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tab_width_reg <= TAB_RESET;
        end else if (psel && penable && pwrite && (reg_idx == REG_TAB_WIDTH)) begin
            tab_width_reg <= pwdata[3:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (reg_idx == REG_TAB_WIDTH) begin
            prdata = {28'd0, tab_width_reg};
        end
    end

    assign s_ready = cmd.take;

    ttcb_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .sts     (sts),
        .cmd     (cmd)
    );

    ttcb_datapath #(
        .COLS (COLS),
        .ROWS (ROWS)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .tab_width (tab_width_reg),
        .s_valid   (s_valid),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule

### tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the text terminal cell buffer. A class mirrors the screen,
// cursor and tab width and predicts one result beat per request beat. The
// run covers writes, tabs, newlines, line wraps and scrolls, and reads inside
// and outside the screen. Tab width is changed over APB between phases, and
// both channels see random gaps and stalls.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import ttcb_pkg::*;

    localparam int COLS = 40;
    localparam int ROWS = 25;

    class screen_mirror;
        logic [7:0] screen [COLS*ROWS];
        int         col;
        int         row;
        int         tab_step;
        ttcb_rsp_t  due_rsp[$];
        int         errors;

        function new();
            foreach (screen[i]) screen[i] = '0;
            col      = 0;
            row      = 0;
            tab_step = TAB_RESET;
            errors   = 0;
        endfunction

        // returns 1 when the screen scrolled
        function bit line_feed();
            col = 0;
            if (row < ROWS - 1) begin
                row++;
                return 1'b0;
            end
            for (int i = 0; i < COLS*(ROWS-1); i++) screen[i] = screen[i+COLS];
            for (int i = COLS*(ROWS-1); i < COLS*ROWS; i++) screen[i] = '0;
            return 1'b1;
        endfunction

        function void take_req(ttcb_req_t q);
            ttcb_rsp_t e;
            e = '0;
            if (q.req_type == REQ_READ) begin
                if (int'(q.read_col) < COLS && int'(q.read_row) < ROWS)
                    e.cell_code = screen[int'(q.read_row)*COLS + int'(q.read_col)];
            end else if (q.char_code == CODE_NEWLINE) begin
                e.scrolled = line_feed();
            end else if (q.char_code == CODE_TAB) begin
                if (col + tab_step < COLS) col += tab_step;
            end else begin
                // cursor past the last column wraps before the store
                if (col >= COLS) e.scrolled = line_feed();
                screen[row*COLS + col] = q.char_code;
                col++;
            end
            e.cursor_col = 6'(col);
            e.cursor_row = 5'(row);
            due_rsp.push_back(e);
        endfunction

        function void flag(string field, logic [7:0] exp_v, logic [7:0] got_v);
            $display("%0t: %s expected %0d got %0d", $time, field, exp_v, got_v);
            errors++;
        endfunction

        function void match_rsp(ttcb_rsp_t got);
            ttcb_rsp_t e;
            if (due_rsp.size() == 0) begin
                $display("%0t: unexpected result beat %h", $time, got);
                errors++;
                return;
            end
            e = due_rsp.pop_front();
            if (got.cell_code !== e.cell_code) flag("cell_code", e.cell_code, got.cell_code);
            if (got.cursor_col !== e.cursor_col)
                flag("cursor_col", 8'(e.cursor_col), 8'(got.cursor_col));
            if (got.cursor_row !== e.cursor_row)
                flag("cursor_row", 8'(e.cursor_row), 8'(got.cursor_row));
            if (got.scrolled !== e.scrolled) flag("scrolled", 8'(e.scrolled), 8'(got.scrolled));
        endfunction
    endclass

    logic        aclk    = 1'b0;
    logic        aresetn = 1'b0;
    logic        psel    = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite  = 1'b0;
    logic [2:0]  paddr   = '0;
    logic [31:0] pwdata  = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_valid = 1'b0;
    logic        s_ready;
    ttcb_req_t   s_data  = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    ttcb_rsp_t   m_data;

    bit           calm = 1'b0;
    screen_mirror mirror = new();

    text_terminal_cell_buffer_unit #(.COLS(COLS), .ROWS(ROWS)) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) mirror.match_rsp(m_data);
            if (s_valid && s_ready) mirror.take_req(s_data);
        end
    end

    // mostly short gaps, a few long ones; none at all while calm
    function automatic int pause_len();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    initial begin
        int hold;
        forever begin
            hold = pause_len();
            if (hold > 0) begin
                m_ready <= 1'b0;
                repeat (hold) @(posedge aclk);
            end
            m_ready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(posedge aclk);
        end
    end

    function automatic logic [7:0] plain_code();
        logic [7:0] c;
        do c = 8'($urandom_range(0, 255));
        while (c == CODE_NEWLINE || c == CODE_TAB);
        return c;
    endfunction

    function automatic ttcb_req_t rd(int c, int r);
        ttcb_req_t q;
        q.req_type  = REQ_READ;
        q.char_code = 8'($urandom_range(0, 255));
        q.read_col  = 6'(c);
        q.read_row  = 5'(r);
        return q;
    endfunction

    function automatic ttcb_req_t wr(logic [7:0] code);
        ttcb_req_t q;
        q.req_type  = REQ_WRITE;
        q.char_code = code;
        q.read_col  = 6'($urandom_range(0, 63));
        q.read_row  = 5'($urandom_range(0, 31));
        return q;
    endfunction

    function automatic ttcb_req_t next_item();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 30) return rd($urandom_range(0, COLS-1), $urandom_range(0, ROWS-1));
        if (pick < 35) return rd($urandom_range(0, 63), $urandom_range(0, 31));
        if (pick < 43) return wr(CODE_NEWLINE);
        if (pick < 50) return wr(CODE_TAB);
        if (pick < 52) return wr(8'($urandom_range(0, 255)));
        return wr(plain_code());
    endfunction

    // valid stays up across back-to-back beats; lowered only for a gap
    task automatic send(ttcb_req_t q);
        int gap;
        gap = pause_len();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= q;
        do @(posedge aclk);
        while (!s_ready);
    endtask

    // the first wait lets the monitor log the last accepted beat
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (mirror.due_rsp.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic set_tab(int width);
        drain();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_TAB_WIDTH, 2'b00};
        pwdata  <= 32'(width);
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        mirror.tab_step = width;
    endtask

    initial begin
        int widths[7] = '{1, 8, 0, 15, 5, 3, 2};
        int n;
        int len;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // reset tab width, code zero, top code, reads off screen
        send(rd(0, 0));
        send(wr(CODE_TAB));
        send(wr(8'h00));
        send(wr(8'hff));
        send(rd(3, 0));
        send(rd(4, 0));
        send(rd(63, 31));
        send(rd(COLS, 0));
        send(rd(0, ROWS));
        send(rd(COLS-1, ROWS-1));
        send(wr(CODE_NEWLINE));
        // tab that would leave the row is dropped
        set_tab(15);
        send(wr(CODE_TAB));
        send(wr(CODE_TAB));
        send(wr(CODE_TAB));
        // fill to the last column, tab while past it, then wrap
        set_tab(8);
        send(wr(CODE_TAB));
        send(wr(8'h41));
        send(wr(8'h42));
        send(wr(CODE_TAB));
        send(wr(8'h43));
        send(rd(COLS-1, 1));
        send(rd(0, 2));
        set_tab(0);
        send(wr(CODE_TAB));

        foreach (widths[p]) begin
            set_tab(widths[p]);
            calm = (p == 2 || p == 5);
            n = 0;
            while (n < 150) begin
                if ($urandom_range(0, 19) == 0) begin
                    // a long run of text often wraps the line, and may scroll too
                    len = $urandom_range(30, 50);
                    repeat (len) send(wr(plain_code()));
                    n += len;
                end else begin
                    send(next_item());
                    n++;
                end
            end
        end
        calm = 1'b0;

        drain();
        if (mirror.errors == 0 && mirror.due_rsp.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial begin
        #50_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule

### sim.f
rtl/ttcb_pkg.sv
rtl/ttcb_ctrl.sv
rtl/ttcb_datapath.sv
rtl/text_terminal_cell_buffer_unit.sv
tb/tb_top.sv
